/* rtl/lowest_free_seat_allocator_top_assert.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the lowest free seat allocator
// Clocked on clk, disabled while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef LOWEST_FREE_SEAT_ALLOCATOR_TOP_ASSERT_SVH
`define LOWEST_FREE_SEAT_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define LFSA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LFSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lfsa_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lfsa_pkg
// Shared constants and controller/datapath interface types.
// -----------------------------------------------------------------------------
package lfsa_pkg;

	localparam int SEATS_DEF     = 64;
	localparam int TIME_BITS_DEF = 20;
	localparam int GUEST_W       = 6;
	localparam int SEAT_OUT_W    = 6;
	localparam int OUT_W         = 8;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture request, restart scan
		logic scan;    // read one release-time entry, advance counter
		logic commit;  // allocate found seat, load result register
	} lfsa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;  // counter sits on the last seat
		logic out_free;   // result register can take a new result
	} lfsa_sts_t;

endpackage

/* rtl/lfsa_ram.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lfsa_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// -----------------------------------------------------------------------------
module lfsa_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/lfsa_datapath.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lfsa_datapath
// Busy bits, release-time RAM, scan pipeline and result register.
// -----------------------------------------------------------------------------
module lfsa_datapath #(
	parameter int SEATS     = lfsa_pkg::SEATS_DEF,
	parameter int TIME_BITS = lfsa_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfsa_pkg::lfsa_cmd_t         cmd,
	output lfsa_pkg::lfsa_sts_t         sts,
	input  logic [lfsa_pkg::GUEST_W-1:0] guest_index,
	input  logic [TIME_BITS-1:0]        arrival_time,
	input  logic [TIME_BITS-1:0]        departure_time,
	input  logic                        target_we,
	input  logic [lfsa_pkg::GUEST_W-1:0] target_wdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lfsa_pkg::OUT_W-1:0]  m_tdata
);

	localparam int SEAT_W = (SEATS > 1) ? $clog2(SEATS) : 1;
	localparam logic [SEAT_W-1:0] LAST_SEAT = SEAT_W'(SEATS - 1);

	logic [lfsa_pkg::GUEST_W-1:0] target_q;
	logic [lfsa_pkg::GUEST_W-1:0] guest_q;
	logic [TIME_BITS-1:0]         arrive_q;
	logic [TIME_BITS-1:0]         depart_q;
	logic [SEAT_W-1:0]            cnt_q;
	logic [SEAT_W-1:0]            idx_s1;
	logic                         vld_s1;
	logic [SEATS-1:0]             busy_q;
	logic                         found_q;
	logic [SEAT_W-1:0]            seat_q;
	logic [TIME_BITS-1:0]         rel_time;
	logic                         expired;
	logic                         seat_free;
	logic                         ram_we;

	logic                          out_valid_q;
	logic [lfsa_pkg::SEAT_OUT_W-1:0] out_seat_q;
	logic                          out_tgt_q;
	logic                          out_nofree_q;

	assign ram_we = cmd.commit && found_q;

	lfsa_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (SEATS)
	) u_rel_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (seat_q),
		.wdata (depart_q),
		.raddr (cnt_q),
		.rdata (rel_time)
	);

	// release time only meaningful for busy seats
	assign expired   = busy_q[idx_s1] && (rel_time <= arrive_q);
	assign seat_free = !busy_q[idx_s1] || expired;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_we) begin
			target_q <= target_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			guest_q  <= guest_index;
			arrive_q <= arrival_time;
			depart_q <= departure_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			idx_s1  <= '0;
			vld_s1  <= 1'b0;
			busy_q  <= '0;
			found_q <= 1'b0;
			seat_q  <= '0;
		end else begin
			vld_s1 <= cmd.scan;
			idx_s1 <= cnt_q;
			if (cmd.load) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				seat_q  <= '0;
			end else if (cmd.scan) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (vld_s1) begin
				if (expired) begin
					busy_q[idx_s1] <= 1'b0;
				end
				if (seat_free && !found_q) begin
					found_q <= 1'b1;
					seat_q  <= idx_s1;
				end
			end
			if (ram_we) begin
				busy_q[seat_q] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_seat_q   <= found_q ? lfsa_pkg::SEAT_OUT_W'(seat_q) : '0;
			out_tgt_q    <= (guest_q == target_q);
			out_nofree_q <= !found_q;
		end
	end

	assign sts.scan_last = (cnt_q == LAST_SEAT);
	assign sts.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_nofree_q, out_tgt_q, out_seat_q};

endmodule

/* rtl/lfsa_ctrl.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lfsa_ctrl
// Sequencer: accept request, scan all seats, drain read pipe, commit result.
// -----------------------------------------------------------------------------
`include "lowest_free_seat_allocator_top_assert.svh"

module lfsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output lfsa_pkg::lfsa_cmd_t cmd,
	input  lfsa_pkg::lfsa_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			// last read still in flight
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`LFSA_ASSERT_NOW(a_commit_room, cmd.commit, sts.out_free, "commit with result register full")
	`LFSA_ASSERT_NEXT(a_scan_to_drain, (state_q == ST_SCAN) && sts.scan_last, state_q == ST_DRAIN, "scan did not end after last seat")
	`LFSA_ASSERT_NEXT(a_load_scan, cmd.load, state_q == ST_SCAN, "accepted request did not start a scan")
	`LFSA_ASSERT_NOW(a_ready_no_scan, s_tready, !cmd.scan && !cmd.commit, "ready while request in progress")

endmodule

/* rtl/lowest_free_seat_allocator_top.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lowest_free_seat_allocator_top
// Gives each arriving guest the lowest free seat after freeing expired seats.
// -----------------------------------------------------------------------------
// One request at a time. s_tready drops when a request is accepted and returns
// after the scan, drain and commit states, so no new request is taken before
// the last one is done. The seat release times sit in one RAM and
// are read one entry per cycle through its read port; expired seats are freed
// and the lowest free seat is picked on the way, then the seat is written.
// Results wait in an output register, so a stalled sink holds the block only
// once the next result is ready. Busy marks clear at reset; no clearing pass.
// Arrival times must be non-decreasing across requests.
module lowest_free_seat_allocator_top #(
	parameter int SEATS     = lfsa_pkg::SEATS_DEF,
	parameter int TIME_BITS = lfsa_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          target_we,
	input  logic [lfsa_pkg::GUEST_W-1:0]  target_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [guest_index, arrival_time, departure_time] from bit 0, zero padded
	input  logic [((lfsa_pkg::GUEST_W + 2 * TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [seat(6), is_target, no_free_seat] from bit 0
	output logic [lfsa_pkg::OUT_W-1:0]    m_tdata
);

	localparam int G = lfsa_pkg::GUEST_W;

	lfsa_pkg::lfsa_cmd_t cmd;
	lfsa_pkg::lfsa_sts_t sts;

	lfsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	lfsa_datapath #(
		.SEATS     (SEATS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.guest_index    (s_tdata[G-1:0]),
		.arrival_time   (s_tdata[G+TIME_BITS-1:G]),
		.departure_time (s_tdata[G+2*TIME_BITS-1:G+TIME_BITS]),
		.target_we      (target_we),
		.target_wdata   (target_wdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

endmodule
